### sv/flg_pkg.sv
package flg_pkg;

	// Delay line geometry
	localparam int DELAY_DEPTH = 2048;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int FRAC_W      = 8;
	localparam int POS_W       = ADDR_W + FRAC_W;

	// Sample and accumulator widths
	localparam int SAMPLE_W = 24;
	localparam int SUM_W    = 32;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	// Sine approximation
	localparam int SINE_BITS = 10;
	localparam int QBITS     = SINE_BITS - 2;
	localparam int TSHIFT    = 16 - QBITS;
	localparam logic [16:0] SIN_C1 = 17'd42334;
	localparam logic [16:0] SIN_C2 = 17'd102944;
	localparam logic [12:0] SIN_C3 = 13'd5210;
	localparam logic [14:0] SIN_MAX = 15'd32767;
	localparam logic [15:0] HALF_Q15 = 16'd32768;
	localparam logic [16:0] UNITY_Q15 = 17'd32768;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;
	localparam int STEP_W     = 23;
	localparam int SWEEP_W    = 19;
	localparam int GAIN_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_STEP = 2'd0,
		REG_SWEEP      = 2'd1,
		REG_FEEDBACK   = 2'd2,
		REG_WET        = 2'd3
	} cfg_reg_t;

	localparam logic [STEP_W-1:0]  RST_PHASE_STEP = 23'd26844;
	localparam logic [SWEEP_W-1:0] RST_SWEEP      = 19'd86016;
	localparam logic [GAIN_W-1:0]  RST_FEEDBACK   = 16'd16384;
	localparam logic [GAIN_W-1:0]  RST_WET        = 16'd16384;

	// Strobes from the sequencer to each channel
	typedef struct packed {
		logic addr;
		logic rd_b;
		logic interp;
		logic mult;
		logic commit;
	} flg_ctl_t;

	// Status of the sweep unit
	typedef struct packed {
		logic busy;
		logic done;
	} flg_lfo_st_t;

	// Clamp to the signed sample range
	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] c;
		c = v;
		if (v > SAT_HI) begin
			c = SAT_HI;
		end else if (v < SAT_LO) begin
			c = SAT_LO;
		end
		return SAMPLE_W'(c);
	endfunction

endpackage

### sv/flg_in_if.sv
interface flg_in_if;
	logic valid;
	logic ready;
	logic signed [flg_pkg::SAMPLE_W-1:0] left_in;
	logic signed [flg_pkg::SAMPLE_W-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

### sv/flg_out_if.sv
interface flg_out_if;
	logic valid;
	logic ready;
	logic signed [flg_pkg::SAMPLE_W-1:0] left_out;
	logic signed [flg_pkg::SAMPLE_W-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

### sv/flg_lfo.sv
// Sine sweep: polynomial sine over four multiply steps, then both delays.
module flg_lfo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [31:0]                     phase,
	input  logic [flg_pkg::SWEEP_W-1:0]     sweep,
	output logic [flg_pkg::POS_W-1:0]       dly_left,
	output logic [flg_pkg::POS_W-1:0]       dly_right,
	output flg_pkg::flg_lfo_st_t            status
);

	typedef enum logic [2:0] {
		LS_IDLE,
		LS_V1,
		LS_V2,
		LS_MAG,
		LS_DLY
	} lfo_state_t;

	lfo_state_t state_q;

	logic [16:0] t_q;
	logic [16:0] t2_q;
	logic [15:0] v1_q;
	logic [16:0] v2_q;
	logic [14:0] mag_q;
	logic        neg_q;
	logic [flg_pkg::POS_W-1:0] dl_q;
	logic [flg_pkg::POS_W-1:0] dr_q;

	logic [flg_pkg::SINE_BITS-1:0] idx;
	logic [1:0]                    quad;
	logic [flg_pkg::QBITS:0]       pos_m;
	logic [16:0]                   t;
	logic [33:0]                   p0;
	logic [29:0]                   p1;
	logic [32:0]                   p2;
	logic [33:0]                   p3;
	logic [18:0]                   s1;
	logic [14:0]                   mag;
	logic [15:0]                   wl;
	logic [15:0]                   wr;
	logic [34:0]                   pl;
	logic [34:0]                   pr;

	// Quarter-wave position, mirrored on odd quarters
	always_comb begin
		idx  = phase[31 -: flg_pkg::SINE_BITS];
		quad = idx[flg_pkg::SINE_BITS-1 -: 2];
		if (quad[0]) begin
			pos_m = (flg_pkg::QBITS+1)'(1 << flg_pkg::QBITS)
				- {1'b0, idx[flg_pkg::QBITS-1:0]};
		end else begin
			pos_m = {1'b0, idx[flg_pkg::QBITS-1:0]};
		end
		t = 17'(pos_m) << flg_pkg::TSHIFT;
	end

	// One product per step
	assign p0 = t * t;
	assign p1 = t2_q * flg_pkg::SIN_C3;
	assign p2 = t2_q * v1_q;
	assign p3 = t_q * v2_q;

	// Round to Q15 and cap
	always_comb begin
		s1 = (19'(p3[33:16]) + 19'd1) >> 1;
		if (s1 > 19'(flg_pkg::SIN_MAX)) begin
			mag = flg_pkg::SIN_MAX;
		end else begin
			mag = s1[14:0];
		end
	end

	// Opposite phases for the two channels
	always_comb begin
		if (neg_q) begin
			wl = flg_pkg::HALF_Q15 - 16'(mag_q);
			wr = flg_pkg::HALF_Q15 + 16'(mag_q);
		end else begin
			wl = flg_pkg::HALF_Q15 + 16'(mag_q);
			wr = flg_pkg::HALF_Q15 - 16'(mag_q);
		end
	end

	assign pl = sweep * wl;
	assign pr = sweep * wr;

	// Step sequencer and its registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
		end else begin
			case (state_q)
				LS_IDLE: begin
					if (start) begin
						t_q     <= t;
						neg_q   <= quad[1];
						t2_q    <= p0[32:16];
						state_q <= LS_V1;
					end
				end
				LS_V1: begin
					v1_q    <= 16'(flg_pkg::SIN_C1 - 17'(p1[29:16]));
					state_q <= LS_V2;
				end
				LS_V2: begin
					v2_q    <= flg_pkg::SIN_C2 - p2[32:16];
					state_q <= LS_MAG;
				end
				LS_MAG: begin
					mag_q   <= mag;
					state_q <= LS_DLY;
				end
				LS_DLY: begin
					dl_q    <= flg_pkg::POS_W'(pl[34:16]) + flg_pkg::POS_W'(256);
					dr_q    <= flg_pkg::POS_W'(pr[34:16]) + flg_pkg::POS_W'(256);
					state_q <= LS_IDLE;
				end
				default: begin
					state_q <= LS_IDLE;
				end
			endcase
		end
	end

	assign dly_left    = dl_q;
	assign dly_right   = dr_q;
	assign status.busy = (state_q != LS_IDLE);
	assign status.done = (state_q == LS_DLY);

endmodule

### sv/flg_chan.sv
// One channel: delay memory, two-tap interpolation, feedback write and mix.
module flg_chan (
	input  logic                                  clk,
	input  flg_pkg::flg_ctl_t                     ctl,
	input  logic [flg_pkg::POS_W-1:0]             dly,
	input  logic [flg_pkg::ADDR_W-1:0]            wp,
	input  logic                                  wrapped,
	input  logic signed [flg_pkg::SAMPLE_W-1:0]   x,
	input  logic signed [flg_pkg::GAIN_W-1:0]     fb,
	input  logic [16:0]                           wet,
	input  logic [16:0]                           dry,
	output logic signed [flg_pkg::SAMPLE_W-1:0]   y
);

	logic signed [flg_pkg::SAMPLE_W-1:0] mem [flg_pkg::DELAY_DEPTH];

	logic [flg_pkg::POS_W-1:0]           pos;
	logic [flg_pkg::ADDR_W-1:0]          i0;
	logic [flg_pkg::ADDR_W-1:0]          i0_next;
	logic [flg_pkg::ADDR_W-1:0]          rd_addr;
	logic signed [flg_pkg::SAMPLE_W-1:0] rd_q;

	logic [flg_pkg::ADDR_W-1:0]          i1_q;
	logic [flg_pkg::FRAC_W-1:0]          f_q;
	logic                                va_q;
	logic                                vb_q;
	logic signed [flg_pkg::SAMPLE_W-1:0] a_q;
	logic signed [flg_pkg::SAMPLE_W-1:0] b;
	logic signed [flg_pkg::SAMPLE_W-1:0] tap_q;
	logic signed [39:0]                  fbp_q;
	logic signed [41:0]                  mix_q;
	logic signed [flg_pkg::SAMPLE_W-1:0] y_q;

	logic [flg_pkg::FRAC_W:0]            w0;
	logic signed [34:0]                  acc;
	logic signed [34:0]                  acc_r;
	logic signed [17:0]                  wet_s;
	logic signed [17:0]                  dry_s;
	logic signed [39:0]                  fb_r;
	logic signed [41:0]                  mix_r;
	logic signed [flg_pkg::SAMPLE_W-1:0] line;
	logic signed [flg_pkg::SAMPLE_W-1:0] ysat;

	// Read position behind the write pointer, wrapping over the line
	assign pos     = {wp, flg_pkg::FRAC_W'(0)} - dly;
	assign i0      = pos[flg_pkg::POS_W-1:flg_pkg::FRAC_W];
	assign i0_next = i0 + flg_pkg::ADDR_W'(1);
	assign rd_addr = ctl.rd_b ? i1_q : i0;

	// Memory: registered read every cycle, write at commit
	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (ctl.commit) begin
			mem[wp] <= line;
		end
	end

	// Linear interpolation, entries never written read as zero
	assign b     = vb_q ? rd_q : '0;
	assign w0    = (flg_pkg::FRAC_W+1)'(1 << flg_pkg::FRAC_W) - {1'b0, f_q};
	assign acc   = a_q * $signed({1'b0, w0}) + b * $signed({2'b0, f_q});
	assign acc_r = acc + 35'sd128;

	assign wet_s = $signed({1'b0, wet});
	assign dry_s = $signed({1'b0, dry});

	// Feedback into the line and dry/wet mix, both rounded and clamped
	assign fb_r  = fbp_q + 40'sd16384;
	assign mix_r = mix_q + 42'sd16384;
	assign line  = flg_pkg::sat_sample(flg_pkg::SUM_W'(x)
		+ flg_pkg::SUM_W'($signed(fb_r[39:15])));
	assign ysat  = flg_pkg::sat_sample(flg_pkg::SUM_W'($signed(mix_r[41:15])));

	always_ff @(posedge clk) begin
		if (ctl.addr) begin
			i1_q <= i0_next;
			f_q  <= pos[flg_pkg::FRAC_W-1:0];
			va_q <= wrapped || (i0 < wp);
			vb_q <= wrapped || (i0_next < wp);
		end
		if (ctl.rd_b) begin
			a_q <= va_q ? rd_q : '0;
		end
		if (ctl.interp) begin
			tap_q <= acc_r[31:8];
		end
		if (ctl.mult) begin
			fbp_q <= tap_q * fb;
			mix_q <= tap_q * wet_s + x * dry_s;
		end
		if (ctl.commit) begin
			y_q <= ysat;
		end
	end

	assign y = y_q;

endmodule

### sv/stereo_flanger.sv
// Stereo flanger. Each accepted sample pair yields one mixed pair; the block
// takes one pair at a time through the four dependent multiply steps of the
// sine sweep, the delay multiply and the two reads of each channel's
// single-read delay memory at adjacent taps. A finished pair waits in the
// output register while the next pair is accepted. No clearing pass follows
// reset: a wrap flag and the write pointer tell which delay entries were
// written, and unwritten ones read as zero. The user must write registers via
// cfg_write/cfg_index/cfg_data only while idle; the block does not check it.
module stereo_flanger (
	input  logic                              clk,
	input  logic                              arst_n,
	flg_in_if.sink                            samples,
	flg_out_if.source                         mixed,
	input  logic                              cfg_write,
	input  logic [flg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [flg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LFO,
		ST_ADDR,
		ST_RDB,
		ST_INTERP,
		ST_MULT,
		ST_MIX
	} seq_state_t;

	seq_state_t state_q;

	logic [flg_pkg::STEP_W-1:0]          step_q;
	logic [flg_pkg::SWEEP_W-1:0]         sweep_q;
	logic signed [flg_pkg::GAIN_W-1:0]   fb_q;
	logic [flg_pkg::GAIN_W-1:0]          wet_q;

	logic [31:0]                         phase_q;
	logic [flg_pkg::ADDR_W-1:0]          wp_q;
	logic                                wrapped_q;
	logic                                out_vld_q;
	logic signed [flg_pkg::SAMPLE_W-1:0] xl_q;
	logic signed [flg_pkg::SAMPLE_W-1:0] xr_q;

	logic                                in_xfer;
	logic                                out_xfer;
	logic [16:0]                         wet_eff;
	logic [16:0]                         dry_eff;
	logic [flg_pkg::POS_W-1:0]           dly_left;
	logic [flg_pkg::POS_W-1:0]           dly_right;
	flg_pkg::flg_lfo_st_t                lfo_st;
	flg_pkg::flg_ctl_t                   ctl;

	assign in_xfer  = samples.valid && samples.ready;
	assign out_xfer = mixed.valid && mixed.ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= flg_pkg::RST_PHASE_STEP;
			sweep_q <= flg_pkg::RST_SWEEP;
			fb_q    <= flg_pkg::RST_FEEDBACK;
			wet_q   <= flg_pkg::RST_WET;
		end else if (cfg_write) begin
			case (flg_pkg::cfg_reg_t'(cfg_index))
				flg_pkg::REG_PHASE_STEP: step_q  <= cfg_data;
				flg_pkg::REG_SWEEP:      sweep_q <= cfg_data[flg_pkg::SWEEP_W-1:0];
				flg_pkg::REG_FEEDBACK:   fb_q    <= cfg_data[flg_pkg::GAIN_W-1:0];
				flg_pkg::REG_WET:        wet_q   <= cfg_data[flg_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Wet share limited to unity
	assign wet_eff = (17'(wet_q) > flg_pkg::UNITY_Q15) ? flg_pkg::UNITY_Q15 : 17'(wet_q);
	assign dry_eff = flg_pkg::UNITY_Q15 - wet_eff;

	// Channel strobes
	always_comb begin
		ctl.addr   = (state_q == ST_ADDR);
		ctl.rd_b   = (state_q == ST_RDB);
		ctl.interp = (state_q == ST_INTERP);
		ctl.mult   = (state_q == ST_MULT);
		ctl.commit = (state_q == ST_MIX) && (!out_vld_q || mixed.ready);
	end

	// Sequencer with pointer, phase and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= '0;
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_LFO;
					end
				end
				ST_LFO: begin
					if (lfo_st.done) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR:   state_q <= ST_RDB;
				ST_RDB:    state_q <= ST_INTERP;
				ST_INTERP: state_q <= ST_MULT;
				ST_MULT:   state_q <= ST_MIX;
				ST_MIX: begin
					if (ctl.commit) begin
						phase_q   <= phase_q + 32'(step_q);
						wp_q      <= wp_q + flg_pkg::ADDR_W'(1);
						if (wp_q == '1) begin
							wrapped_q <= 1'b1;
						end
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// New result wins over the transfer of the previous one
			if (ctl.commit) begin
				out_vld_q <= 1'b1;
			end else if (out_xfer) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Input pair held for the whole item
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			xl_q <= samples.left_in;
			xr_q <= samples.right_in;
		end
	end

	assign samples.ready = (state_q == ST_IDLE);
	assign mixed.valid   = out_vld_q;

	flg_lfo u_lfo (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_xfer),
		.phase     (phase_q),
		.sweep     (sweep_q),
		.dly_left  (dly_left),
		.dly_right (dly_right),
		.status    (lfo_st)
	);

	flg_chan u_left (
		.clk     (clk),
		.ctl     (ctl),
		.dly     (dly_left),
		.wp      (wp_q),
		.wrapped (wrapped_q),
		.x       (xl_q),
		.fb      (fb_q),
		.wet     (wet_eff),
		.dry     (dry_eff),
		.y       (mixed.left_out)
	);

	flg_chan u_right (
		.clk     (clk),
		.ctl     (ctl),
		.dly     (dly_right),
		.wp      (wp_q),
		.wrapped (wrapped_q),
		.x       (xr_q),
		.fb      (fb_q),
		.wet     (wet_eff),
		.dry     (dry_eff),
		.y       (mixed.right_out)
	);

	// Sweep unit finishes only while the sequencer waits for it
	a_lfo_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		lfo_st.done |-> state_q == ST_LFO)
		else $error("sweep unit finished outside its wait state");

	// A new pair never arrives while the sweep unit is still busy
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> !lfo_st.busy)
		else $error("pair transfer while sweep unit busy");

	// Each commit advances the write pointer by one
	a_wp_advance: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> wp_q == $past(wp_q) + flg_pkg::ADDR_W'(1))
		else $error("write pointer did not advance on commit");

	// The wrap flag is raised only as the pointer returns to zero
	a_wrap_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wrapped_q) |-> wp_q == '0)
		else $error("wrap flag raised away from pointer zero");

endmodule
